/* hdl/bwdc_pkg.sv */
// shared types and constants of the bottom watering dose controller
`default_nettype none
package bwdc_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);

	localparam logic [11:0] SOIL_DRY = 12'd2585;
	localparam logic [11:0] SOIL_WET = 12'd1700;
	localparam logic [11:0] SOIL_MIN = 12'd800;
	localparam logic [11:0] SOIL_MAX = 12'd3200;
	localparam logic [11:0] LEAK_THRESH = 12'd200;
	localparam logic [31:0] LEAK_DEBOUNCE = 32'd3000;
	localparam logic [31:0] STALE_MS = 32'd30000;
	localparam logic [31:0] PUMP_CEILING = 32'd165000;
	localparam logic [31:0] PLATEAU_WIN = 32'd1800000;
	localparam logic [14:0] PCT_FULL = 15'd25600;
	localparam logic [6:0] MAX_DOSE = 7'd100;
	localparam logic [19:0] DELIV_MAX = 20'hFFFFF;

	localparam logic [1:0] MAINT_NONE = 2'd0;
	localparam logic [1:0] MAINT_ENTER = 2'd1;
	localparam logic [1:0] MAINT_ARM = 2'd2;

	localparam logic [2:0] CFG_TRIGGER = 3'd0;
	localparam logic [2:0] CFG_TARGET = 3'd1;
	localparam logic [2:0] CFG_FIRST = 3'd2;
	localparam logic [2:0] CFG_SUPPL = 3'd3;
	localparam logic [2:0] CFG_CAP = 3'd4;
	localparam logic [2:0] CFG_ABSORB = 3'd5;
	localparam logic [2:0] CFG_SETTLE = 3'd6;
	localparam logic [2:0] CFG_GRACE = 3'd7;

	localparam logic [3:0] R_NONE = 4'd0;
	localparam logic [3:0] R_EMPTY = 4'd1;
	localparam logic [3:0] R_CAPPED = 4'd2;
	localparam logic [3:0] R_DONE = 4'd3;
	localparam logic [3:0] R_STALL = 4'd4;
	localparam logic [3:0] R_FAILED = 4'd5;
	localparam logic [3:0] R_RUNTIME = 4'd6;
	localparam logic [3:0] R_MAINT = 4'd7;
	localparam logic [3:0] R_LEAK = 4'd8;
	localparam logic [3:0] R_ABORT = 4'd9;
	localparam logic [3:0] R_STALE = 4'd10;
	localparam logic [3:0] R_RECOVERY = 4'd11;

	typedef struct packed {
		logic [1:0] maint;
		logic ack;
		logic abrt;
		logic start;
		logic tank;
		logic [11:0] leak;
		logic [11:0] soil;
		logic sample;
		logic [31:0] now;
	} in_t;

	typedef struct packed {
		logic [31:0] now;
		logic [14:0] ema;
		logic tank_seen;
		logic leak_seen;
		logic stale;
		logic leak_ok;
		logic start;
		logic abrt;
		logic ack;
		logic [1:0] maint;
	} tick_t;

	typedef struct packed {
		logic [6:0] trigger_percent;
		logic [6:0] target_percent;
		logic [6:0] first_dose_ml;
		logic [6:0] supplement_ml;
		logic [9:0] cap_ml;
		logic [6:0] absorb_rise_percent;
		logic [26:0] settle_wait_ms;
		logic [26:0] grace_len_ms;
	} cfg_t;

endpackage
`default_nettype wire

/* hdl/bwdc_front.sv */
// front end: soil percent pipeline, ema, leak debounce and stale probe tracking
`default_nettype none
module bwdc_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [63:0] s_tdata,
	input wire logic q_full,
	output logic push,
	output bwdc_pkg::tick_t item
);

	localparam logic [25:0] RECIP_885 = 26'd38824563;
	localparam logic [22:0] RECIP_10 = 23'd6710887;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;
	bwdc_pkg::in_t in_s1, in_s2, in_s3, in_s4;
	logic [24:0] n_s2, n_s3;
	logic [15:0] qe_s3;
	logic [14:0] pct_s4;

	logic [9:0] diff;
	logic [50:0] prod_div;
	logic [24:0] rem;
	logic [15:0] q_fix;
	logic [14:0] pct_next;

	logic [14:0] ema_q, ema_n;
	logic seen_q, seen_n;
	logic [31:0] lvt_q, lvt_n;
	logic leak_seen_q, leak_seen_n;
	logic tank_q, tank_n;
	logic ltim_q, ltim_n;
	logic [31:0] lstart_q, lstart_n;
	logic [17:0] ema_sum;
	logic [40:0] ema_prod;
	logic soil_ok;
	logic stale;
	logic leak_ok;

	assign adv = !q_full;
	assign s_tready = adv;
	assign push = v_s4 && adv;

	assign diff = 10'(bwdc_pkg::SOIL_DRY - in_s1.soil);
	assign prod_div = 51'(n_s2) * 51'(RECIP_885);

	always_comb begin
		rem = n_s3 - 25'(qe_s3) * 25'd885;
		q_fix = (rem >= 25'd885) ? qe_s3 + 16'd1 : qe_s3;
		if (in_s3.soil <= bwdc_pkg::SOIL_WET) begin
			pct_next = bwdc_pkg::PCT_FULL;
		end else if (in_s3.soil >= bwdc_pkg::SOIL_DRY) begin
			pct_next = '0;
		end else begin
			pct_next = q_fix[14:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			in_s1 <= bwdc_pkg::in_t'(s_tdata[62:0]);
			in_s2 <= in_s1;
			n_s2 <= 25'(diff) * 25'd25600 + 25'd442;
			in_s3 <= in_s2;
			n_s3 <= n_s2;
			qe_s3 <= prod_div[50:35];
			in_s4 <= in_s3;
			pct_s4 <= pct_next;
		end
	end

	always_comb begin
		ema_n = ema_q;
		seen_n = seen_q;
		lvt_n = lvt_q;
		leak_seen_n = leak_seen_q;
		tank_n = tank_q;
		ltim_n = ltim_q;
		lstart_n = lstart_q;
		soil_ok = (in_s4.soil >= bwdc_pkg::SOIL_MIN) && (in_s4.soil <= bwdc_pkg::SOIL_MAX);
		ema_sum = 18'(pct_s4) + 18'(ema_q) * 18'd9 + 18'd5;
		ema_prod = 41'(ema_sum) * 41'(RECIP_10);
		if (in_s4.sample) begin
			leak_seen_n = in_s4.leak >= bwdc_pkg::LEAK_THRESH;
			tank_n = in_s4.tank;
			if (soil_ok) begin
				lvt_n = in_s4.now;
				ema_n = seen_q ? ema_prod[40:26] : pct_s4;
				seen_n = 1'b1;
			end
		end
		stale = !seen_n || ((in_s4.now - lvt_n) > bwdc_pkg::STALE_MS);
		if (leak_seen_n) begin
			if (!ltim_q) begin
				ltim_n = 1'b1;
				lstart_n = in_s4.now;
			end
		end else begin
			ltim_n = 1'b0;
		end
		leak_ok = ltim_n && ((in_s4.now - lstart_n) >= bwdc_pkg::LEAK_DEBOUNCE);

		item.now = in_s4.now;
		item.ema = ema_n;
		item.tank_seen = tank_n;
		item.leak_seen = leak_seen_n;
		item.stale = stale;
		item.leak_ok = leak_ok;
		item.start = in_s4.start;
		item.abrt = in_s4.abrt;
		item.ack = in_s4.ack;
		item.maint = in_s4.maint;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ema_q <= '0;
			seen_q <= 1'b0;
			lvt_q <= '0;
			leak_seen_q <= 1'b0;
			tank_q <= 1'b0;
			ltim_q <= 1'b0;
			lstart_q <= '0;
		end else if (push) begin
			ema_q <= ema_n;
			seen_q <= seen_n;
			lvt_q <= lvt_n;
			leak_seen_q <= leak_seen_n;
			tank_q <= tank_n;
			ltim_q <= ltim_n;
			lstart_q <= lstart_n;
		end
	end

endmodule
`default_nettype wire

/* hdl/bwdc_fifo.sv */
// small register queue between front end and dose sequencer
`default_nettype none
module bwdc_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire bwdc_pkg::tick_t wr_item,
	input wire logic pop,
	output bwdc_pkg::tick_t rd_item,
	output logic full,
	output logic nonempty
);

	bwdc_pkg::tick_t mem_q [bwdc_pkg::QDEPTH];
	logic [bwdc_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [bwdc_pkg::QPTR_W:0] cnt_q;

	assign full = cnt_q == (bwdc_pkg::QPTR_W+1)'(bwdc_pkg::QDEPTH);
	assign nonempty = cnt_q != '0;
	assign rd_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/bwdc_back.sv */
// dose sequencer: watering state machine, volume accounting and result register
`default_nettype none
module bwdc_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire bwdc_pkg::cfg_t cfg,
	input wire logic q_valid,
	input wire bwdc_pkg::tick_t tk,
	output logic q_pop,
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [47:0] m_tdata
);

	typedef enum logic [3:0] {
		MD_MONITOR = 4'd0,
		MD_DOSING = 4'd1,
		MD_SETTLE = 4'd2,
		MD_GRACE = 4'd3,
		MD_EMPTY = 4'd4,
		MD_STOPPED = 4'd5,
		MD_LEAK = 4'd6,
		MD_HOLD = 4'd7,
		MD_SENSOR = 4'd8
	} mode_t;

	localparam logic [20:0] RECIP_1000 = 21'd1073742;

	mode_t mode_q, mode_n, prev;
	logic pump_q, pump_n;
	logic [31:0] pstart_q, pstart_n;
	logic maint_q, maint_n;
	logic [19:0] deliv_q, deliv_n;
	logic [7:0] doses_q, doses_n;
	logic grace_q, grace_n;
	logic [14:0] pre_q, pre_n, stall_q, stall_n, pref_q, pref_n, ema_q;
	logic [31:0] dstart_q, dstart_n, sstart_q, sstart_n, ptime_q, ptime_n;
	logic [31:0] gstart_q, gstart_n;
	logic [16:0] dlen_q, dlen_n;
	logic parm_q, parm_n;
	logic [3:0] reason_q, reason_n;
	logic [9:0] vol_q;
	logic chg_q;
	logic ph_q;
	logic out_v_q;

	logic active, at_target, do_judge, do_dose, sess;
	logic [6:0] ml;
	logic [9:0] vol_eff;
	logic signed [11:0] budget;
	logic signed [15:0] rise, grace_rise, pdiff, absorb_s;
	logic [31:0] on_ms;
	logic [20:0] deliv_sum;
	logic [40:0] vol_prod;
	logic [10:0] vol_raw;

	assign q_pop = !ph_q && q_valid && (!out_v_q || m_tready);
	assign m_tvalid = out_v_q;
	assign m_tdata = {4'b0, chg_q, maint_q, ema_q, doses_q, vol_q, reason_q,
		4'(mode_q), pump_q};

	assign vol_prod = 41'(deliv_q) * 41'(RECIP_1000);
	assign vol_raw = vol_prod[40:30];

	always_comb begin
		mode_n = mode_q;
		pump_n = pump_q;
		pstart_n = pstart_q;
		maint_n = maint_q;
		deliv_n = deliv_q;
		doses_n = doses_q;
		grace_n = grace_q;
		pre_n = pre_q;
		stall_n = stall_q;
		pref_n = pref_q;
		dstart_n = dstart_q;
		sstart_n = sstart_q;
		ptime_n = ptime_q;
		gstart_n = gstart_q;
		dlen_n = dlen_q;
		parm_n = parm_q;
		reason_n = reason_q;
		do_judge = 1'b0;
		do_dose = 1'b0;
		sess = 1'b0;
		ml = '0;
		budget = '0;
		on_ms = '0;
		deliv_sum = '0;
		absorb_s = $signed({1'b0, cfg.absorb_rise_percent, 8'b0});
		at_target = tk.ema >= {cfg.target_percent, 8'b0};
		rise = $signed({1'b0, tk.ema}) - $signed({1'b0, pre_q});
		grace_rise = $signed({1'b0, tk.ema}) - $signed({1'b0, stall_q});
		pdiff = $signed({1'b0, tk.ema}) - $signed({1'b0, pref_q});

		if (pump_q && ((tk.now - pstart_q) >= bwdc_pkg::PUMP_CEILING)) begin
			pump_n = 1'b0;
			reason_n = bwdc_pkg::R_RUNTIME;
			mode_n = MD_STOPPED;
		end
		prev = mode_n;
		active = (prev == MD_DOSING) || (prev == MD_SETTLE) || (prev == MD_GRACE);

		if (tk.maint == bwdc_pkg::MAINT_ENTER && !maint_q) begin
			maint_n = 1'b1;
			if (active) begin
				pump_n = 1'b0;
				reason_n = bwdc_pkg::R_MAINT;
				mode_n = MD_STOPPED;
			end
		end else if (tk.maint == bwdc_pkg::MAINT_ARM && maint_q) begin
			maint_n = 1'b0;
		end

		if (tk.leak_ok) begin
			pump_n = 1'b0;
			reason_n = bwdc_pkg::R_LEAK;
			mode_n = MD_LEAK;
		end else if (tk.abrt) begin
			pump_n = 1'b0;
			reason_n = bwdc_pkg::R_ABORT;
			mode_n = MD_STOPPED;
		end else if (tk.stale && active) begin
			pump_n = 1'b0;
			reason_n = bwdc_pkg::R_STALE;
			mode_n = MD_SENSOR;
		end else if (mode_n == MD_LEAK) begin
			if (tk.ack && !tk.leak_seen) begin
				reason_n = bwdc_pkg::R_NONE;
				mode_n = MD_MONITOR;
			end
		end else if (mode_n == MD_SENSOR) begin
			pump_n = 1'b0;
			if (tk.ack && !tk.stale) begin
				reason_n = bwdc_pkg::R_NONE;
				mode_n = MD_MONITOR;
			end
		end else if (mode_n == MD_STOPPED) begin
			if (tk.ack) begin
				deliv_n = '0;
				doses_n = '0;
				grace_n = 1'b0;
				reason_n = bwdc_pkg::R_NONE;
				mode_n = MD_MONITOR;
			end
		end else if (mode_n == MD_HOLD) begin
			pump_n = 1'b0;
			if (tk.ack) begin
				reason_n = bwdc_pkg::R_RECOVERY;
				mode_n = MD_STOPPED;
			end
		end else if (tk.tank_seen && active) begin
			pump_n = 1'b0;
			reason_n = bwdc_pkg::R_EMPTY;
			mode_n = MD_STOPPED;
		end else begin
			case (mode_n)
				MD_EMPTY: begin
					if (!tk.tank_seen) begin
						mode_n = MD_MONITOR;
					end
				end
				MD_MONITOR: begin
					if (tk.tank_seen) begin
						mode_n = MD_EMPTY;
					end else if (tk.start) begin
						sess = !tk.stale;
					end else begin
						sess = !maint_n && !tk.stale &&
							(tk.ema <= {cfg.trigger_percent, 8'b0});
					end
				end
				MD_DOSING: begin
					if ((tk.now - dstart_q) >= 32'(dlen_q)) begin
						pump_n = 1'b0;
						sstart_n = tk.now;
						parm_n = 1'b0;
						pref_n = '0;
						mode_n = MD_SETTLE;
					end
				end
				MD_SETTLE: begin
					if (at_target || tk.ack) begin
						do_judge = 1'b1;
					end else if ((tk.now - sstart_q) >= 32'(cfg.settle_wait_ms)) begin
						if (!parm_q) begin
							parm_n = 1'b1;
							pref_n = tk.ema;
							ptime_n = tk.now;
						end else if ((tk.now - ptime_q) >= bwdc_pkg::PLATEAU_WIN) begin
							if (pdiff <= 16'sd256 && pdiff >= -16'sd256) begin
								do_judge = 1'b1;
							end else begin
								pref_n = tk.ema;
								ptime_n = tk.now;
							end
						end
					end
				end
				MD_GRACE: begin
					if (at_target) begin
						do_judge = 1'b1;
					end else if (tk.ack || ((tk.now - gstart_q) >= 32'(cfg.grace_len_ms))) begin
						if (grace_rise >= absorb_s) begin
							do_judge = 1'b1;
						end else begin
							pump_n = 1'b0;
							reason_n = bwdc_pkg::R_FAILED;
							mode_n = MD_STOPPED;
						end
					end
				end
				default: begin
				end
			endcase
		end

		if (sess) begin
			deliv_n = '0;
			doses_n = '0;
			grace_n = 1'b0;
			reason_n = bwdc_pkg::R_NONE;
			do_dose = 1'b1;
			ml = cfg.first_dose_ml;
		end

		if (do_judge) begin
			if (at_target) begin
				pump_n = 1'b0;
				reason_n = bwdc_pkg::R_DONE;
				mode_n = MD_MONITOR;
			end else if (rise >= absorb_s) begin
				if (vol_q < cfg.cap_ml) begin
					do_dose = 1'b1;
					ml = cfg.supplement_ml;
				end else begin
					pump_n = 1'b0;
					reason_n = bwdc_pkg::R_CAPPED;
					mode_n = MD_STOPPED;
				end
			end else if (!grace_q) begin
				grace_n = 1'b1;
				stall_n = tk.ema;
				gstart_n = tk.now;
				mode_n = MD_GRACE;
				reason_n = bwdc_pkg::R_STALL;
			end else begin
				pump_n = 1'b0;
				reason_n = bwdc_pkg::R_FAILED;
				mode_n = MD_STOPPED;
			end
		end

		vol_eff = sess ? '0 : vol_q;
		if (do_dose) begin
			budget = $signed({2'b0, cfg.cap_ml}) - $signed({2'b0, vol_eff});
			if (tk.tank_seen) begin
				pump_n = 1'b0;
				reason_n = bwdc_pkg::R_EMPTY;
				mode_n = MD_STOPPED;
			end else if (budget <= 12'sd0) begin
				pump_n = 1'b0;
				reason_n = bwdc_pkg::R_CAPPED;
				mode_n = MD_STOPPED;
			end else begin
				if (ml > bwdc_pkg::MAX_DOSE) begin
					ml = bwdc_pkg::MAX_DOSE;
				end
				if ($signed({5'b0, ml}) > budget) begin
					ml = budget[6:0];
				end
				if (ml != '0) begin
					pre_n = tk.ema;
					dlen_n = 17'(ml) * 17'd1000;
					dstart_n = tk.now;
					if (doses_n != 8'hFF) begin
						doses_n = doses_n + 8'd1;
					end
					mode_n = MD_DOSING;
					if (!pump_n) begin
						pump_n = 1'b1;
						pstart_n = tk.now;
					end
				end
			end
		end

		if (prev == MD_DOSING && mode_n != MD_DOSING) begin
			on_ms = tk.now - dstart_q;
			if (on_ms > 32'(dlen_q)) begin
				on_ms = 32'(dlen_q);
			end
			deliv_sum = 21'(deliv_n) + 21'(on_ms[16:0]);
			deliv_n = (deliv_sum > 21'(bwdc_pkg::DELIV_MAX)) ? bwdc_pkg::DELIV_MAX :
				deliv_sum[19:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MD_MONITOR;
			pump_q <= 1'b0;
			pstart_q <= '0;
			maint_q <= 1'b1;
			deliv_q <= '0;
			doses_q <= '0;
			grace_q <= 1'b0;
			pre_q <= '0;
			stall_q <= '0;
			pref_q <= '0;
			dstart_q <= '0;
			sstart_q <= '0;
			ptime_q <= '0;
			gstart_q <= '0;
			dlen_q <= '0;
			parm_q <= 1'b0;
			reason_q <= bwdc_pkg::R_NONE;
			vol_q <= '0;
			ema_q <= '0;
			chg_q <= 1'b0;
			ph_q <= 1'b0;
			out_v_q <= 1'b0;
		end else if (ph_q) begin
			vol_q <= (vol_raw > 11'd1023) ? 10'd1023 : vol_raw[9:0];
			out_v_q <= 1'b1;
			ph_q <= 1'b0;
		end else if (q_pop) begin
			mode_q <= mode_n;
			pump_q <= pump_n;
			pstart_q <= pstart_n;
			maint_q <= maint_n;
			deliv_q <= deliv_n;
			doses_q <= doses_n;
			grace_q <= grace_n;
			pre_q <= pre_n;
			stall_q <= stall_n;
			pref_q <= pref_n;
			dstart_q <= dstart_n;
			sstart_q <= sstart_n;
			ptime_q <= ptime_n;
			gstart_q <= gstart_n;
			dlen_q <= dlen_n;
			parm_q <= parm_n;
			reason_q <= reason_n;
			ema_q <= tk.ema;
			chg_q <= mode_n != prev;
			out_v_q <= 1'b0;
			ph_q <= 1'b1;
		end else if (out_v_q && m_tready) begin
			out_v_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

/* hdl/bottom_watering_dose_controller_unit.sv */
// top level: settings registers, front end, request queue and dose sequencer
// a request passes front end stages s1 to s4, the queue, the sequencer step and the volume update
// the sequencer steps one request and updates its volume before it takes the next, and waits for a held result
// the front end takes one request per cycle while the queue is not full and buffers through a 4 entry queue
// reset: valid flags, queue pointers and sequencer state cleared, monitor state, maintenance on, settings at defaults
`default_nettype none
module bottom_watering_dose_controller_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// now_ms, sample_new, soil_adc, leak_adc, tank_empty, start_request,
	// abort_request, ack_press, maint_request
	input wire logic [63:0] s_tdata,
	output logic m_tvalid,
	input wire logic m_tready,
	// pump_drive, fsm_state, reason_code, session_volume_ml, dose_total,
	// moisture_q8, maintenance_on, state_changed
	output logic [47:0] m_tdata,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [26:0] cfg_data
);

	bwdc_pkg::cfg_t cfg_q;
	bwdc_pkg::tick_t wr_item, rd_item;
	logic push, pop, full, nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_percent <= 7'd30;
			cfg_q.target_percent <= 7'd70;
			cfg_q.first_dose_ml <= 7'd100;
			cfg_q.supplement_ml <= 7'd0;
			cfg_q.cap_ml <= 10'd100;
			cfg_q.absorb_rise_percent <= 7'd7;
			cfg_q.settle_wait_ms <= 27'd10800000;
			cfg_q.grace_len_ms <= 27'd5400000;
		end else if (cfg_we) begin
			case (cfg_index)
				bwdc_pkg::CFG_TRIGGER: cfg_q.trigger_percent <= cfg_data[6:0];
				bwdc_pkg::CFG_TARGET: cfg_q.target_percent <= cfg_data[6:0];
				bwdc_pkg::CFG_FIRST: cfg_q.first_dose_ml <= cfg_data[6:0];
				bwdc_pkg::CFG_SUPPL: cfg_q.supplement_ml <= cfg_data[6:0];
				bwdc_pkg::CFG_CAP: cfg_q.cap_ml <= cfg_data[9:0];
				bwdc_pkg::CFG_ABSORB: cfg_q.absorb_rise_percent <= cfg_data[6:0];
				bwdc_pkg::CFG_SETTLE: cfg_q.settle_wait_ms <= cfg_data;
				bwdc_pkg::CFG_GRACE: cfg_q.grace_len_ms <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	bwdc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.q_full(full),
		.push(push),
		.item(wr_item)
	);

	bwdc_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_item(wr_item),
		.pop(pop),
		.rd_item(rd_item),
		.full(full),
		.nonempty(nonempty)
	);

	bwdc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(nonempty),
		.tk(rd_item),
		.q_pop(pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

endmodule
`default_nettype wire
